FILE: src/sqs_pkg.sv
// Shared types, constants and helper functions for the scale quantizer.
// Used by sqs_cfg_regs, sqs_snap and scale_quantizer_snap_core; depends on nothing.
package sqs_pkg;

  localparam int unsigned NoteWidth   = 7;
  localparam int unsigned PitchWidth  = 4;
  localparam int unsigned KindWidth   = 4;
  localparam int unsigned MaskWidth   = 12;
  localparam int unsigned CfgIdxWidth = 1;
  localparam int unsigned CfgWidth    = 4;
  localparam int unsigned SearchSpan  = 6;
  localparam int unsigned WinWidth    = 2 * SearchSpan + 1;
  localparam logic [NoteWidth-1:0] NoteMax = 7'd127;

  typedef logic [NoteWidth-1:0]  note_t;
  typedef logic [PitchWidth-1:0] pitch_t;
  typedef logic [KindWidth-1:0]  kind_t;
  typedef logic [MaskWidth-1:0]  mask_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_ROOT = 1'b0,
    CFG_KIND = 1'b1
  } cfg_idx_t;

  typedef enum logic [KindWidth-1:0] {
    KIND_CHROMATIC   = 4'd0,
    KIND_MAJOR       = 4'd1,
    KIND_NAT_MINOR   = 4'd2,
    KIND_HARM_MINOR  = 4'd3,
    KIND_MEL_MINOR   = 4'd4,
    KIND_DORIAN      = 4'd5,
    KIND_PHRYGIAN    = 4'd6,
    KIND_LYDIAN      = 4'd7,
    KIND_MIXOLYDIAN  = 4'd8,
    KIND_LOCRIAN     = 4'd9,
    KIND_PENTA_MAJOR = 4'd10,
    KIND_PENTA_MINOR = 4'd11,
    KIND_BLUES       = 4'd12,
    KIND_WHOLE_TONE  = 4'd13,
    KIND_UNDEF_A     = 4'd14,
    KIND_UNDEF_B     = 4'd15
  } scale_kind_t;

  typedef struct packed {
    pitch_t root;
    kind_t  kind;
  } scale_cfg_t;

  // Degree mask of each scale kind; bit d set means degree d is in the scale.
  function automatic mask_t kind_mask(input kind_t kind);
    mask_t m;
    case (scale_kind_t'(kind))
      KIND_CHROMATIC:   m = 12'hFFF;
      KIND_MAJOR:       m = 12'hAB5;
      KIND_NAT_MINOR:   m = 12'h5AD;
      KIND_HARM_MINOR:  m = 12'h9AD;
      KIND_MEL_MINOR:   m = 12'hAAD;
      KIND_DORIAN:      m = 12'h6AD;
      KIND_PHRYGIAN:    m = 12'h5AB;
      KIND_LYDIAN:      m = 12'hAD5;
      KIND_MIXOLYDIAN:  m = 12'h6B5;
      KIND_LOCRIAN:     m = 12'h56B;
      KIND_PENTA_MAJOR: m = 12'h295;
      KIND_PENTA_MINOR: m = 12'h4A9;
      KIND_BLUES:       m = 12'h4E9;
      KIND_WHOLE_TONE:  m = 12'h555;
      default:          m = 12'hFFF;
    endcase
    return m;
  endfunction

  // Pitch class of a note: the quotient comes from a reciprocal multiply,
  // which is exact for every seven-bit note.
  function automatic pitch_t note_pitch(input note_t n);
    logic [12:0] prod;
    logic [3:0]  quo;
    logic [7:0]  sub;
    prod = {6'd0, n} * 13'd43;
    quo  = prod[12:9];
    sub  = {4'd0, quo} * 8'd12;
    return pitch_t'({1'b0, n} - sub);
  endfunction

endpackage

FILE: src/scale_quantizer_snap_core.sv
// Top level of the scale quantizer: input register, snap logic and result register.
// Depends on sqs_pkg, sqs_cfg_regs and sqs_snap.
//
// One note is taken on every cycle in which start is high; busy is high only
// during reset. Each item gives exactly one result, shown for a single cycle
// with done high; the receiver cannot stall, so results must be captured on
// that cycle. The item passes through the input register and then the result
// register around the snap logic. Configuration should be written only
// while no item is in flight.
module scale_quantizer_snap_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [6:0]                       note_number,
  output logic                             done,
  output logic [6:0]                       snapped_note,
  output logic                             was_in_scale,
  input  logic                             cfg_write,
  input  logic [sqs_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  logic [sqs_pkg::CfgWidth-1:0]     cfg_data
);

  sqs_pkg::scale_cfg_t scale_cfg;
  sqs_pkg::note_t      note_q;
  logic                valid_q;
  sqs_pkg::note_t      snapped_next;
  logic                in_scale_next;

  assign busy = rst;

  sqs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .scale_cfg (scale_cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      note_q <= note_number;
    end
  end

  sqs_snap u_snap (
    .scale_cfg (scale_cfg),
    .note      (note_q),
    .snapped   (snapped_next),
    .in_scale  (in_scale_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_q) begin
      snapped_note <= snapped_next;
      was_in_scale <= in_scale_next;
    end
  end

  a_result_follows_item: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted item produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(valid_q))
    else $error("result without a registered item");

  a_in_scale_passes: assert property (@(posedge clk) disable iff (rst)
    (done && was_in_scale) |-> snapped_note == $past(note_q))
    else $error("in-scale note was altered");

  a_snap_distance: assert property (@(posedge clk) disable iff (rst)
    done |-> ((snapped_note >= $past(note_q) ? snapped_note - $past(note_q)
                                              : $past(note_q) - snapped_note) <= 7'd6))
    else $error("snapped note too far from input");

endmodule

FILE: src/sqs_cfg_regs.sv
// Configuration registers of the scale quantizer: root pitch class and scale kind.
// Depends on sqs_pkg.
module sqs_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sqs_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  logic [sqs_pkg::CfgWidth-1:0]     cfg_data,
  output sqs_pkg::scale_cfg_t              scale_cfg
);

  sqs_pkg::pitch_t root;
  sqs_pkg::kind_t  kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      root <= '0;
      kind <= '0;
    end else if (cfg_write) begin
      case (sqs_pkg::cfg_idx_t'(cfg_index))
        sqs_pkg::CFG_ROOT: root <= cfg_data;
        sqs_pkg::CFG_KIND: kind <= cfg_data;
        default: ;
      endcase
    end
  end

  assign scale_cfg.root = root;
  assign scale_cfg.kind = kind;

endmodule

FILE: src/sqs_snap.sv
// Combinational snap of one note to the configured scale.
// Depends on sqs_pkg.
module sqs_snap (
  input  sqs_pkg::scale_cfg_t scale_cfg,
  input  sqs_pkg::note_t      note,
  output sqs_pkg::note_t      snapped,
  output logic                in_scale
);

  sqs_pkg::mask_t                       mask;
  sqs_pkg::pitch_t                      root_pc;
  sqs_pkg::pitch_t                      note_pc;
  logic [sqs_pkg::PitchWidth:0]         diff;
  sqs_pkg::pitch_t                      degree;
  logic [3*sqs_pkg::MaskWidth-1:0]      triple;
  logic [3*sqs_pkg::MaskWidth-1:0]      shifted;
  logic [sqs_pkg::WinWidth-1:0]         win;
  logic                                 found;
  sqs_pkg::note_t                       pick;

  always_comb begin
    mask    = sqs_pkg::kind_mask(scale_cfg.kind);
    root_pc = (scale_cfg.root >= 4'd12) ? scale_cfg.root - 4'd12 : scale_cfg.root;
    note_pc = sqs_pkg::note_pitch(note);
    diff    = {1'b0, note_pc} - {1'b0, root_pc};
    degree  = diff[sqs_pkg::PitchWidth] ? diff[3:0] + 4'd12 : diff[3:0];
    // Window bit i tells whether the note at offset i - SearchSpan is in the scale.
    triple  = {mask, mask, mask};
    shifted = triple >> (6'(degree) + 6'(sqs_pkg::SearchSpan));
    win     = shifted[sqs_pkg::WinWidth-1:0];
  end

  always_comb begin
    found = 1'b0;
    pick  = note;
    for (int d = 1; d <= sqs_pkg::SearchSpan; d++) begin
      if (!found && win[sqs_pkg::SearchSpan-d] && note >= 7'(d)) begin
        found = 1'b1;
        pick  = note - 7'(d);
      end
      if (!found && win[sqs_pkg::SearchSpan+d] && note <= sqs_pkg::NoteMax - 7'(d)) begin
        found = 1'b1;
        pick  = note + 7'(d);
      end
    end
  end

  assign in_scale = win[sqs_pkg::SearchSpan];
  assign snapped  = in_scale ? note : pick;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for scale_quantizer_snap_core, using random notes and scale settings.
// Needs sqs_pkg and the core; predicts every snapped note and checks it against the block.
module tb_top;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned NotesPerPhase = 150;
  localparam int unsigned PhaseCount = 9;

  typedef enum logic {
    ACT_NOTE = 1'b0,
    ACT_CFG  = 1'b1
  } act_t;

  typedef struct packed {
    act_t                         act;
    sqs_pkg::note_t               note;
    sqs_pkg::cfg_idx_t            idx;
    logic [sqs_pkg::CfgWidth-1:0] data;
    logic [6:0]                   idle_pct;
  } step_t;

  typedef struct packed {
    sqs_pkg::note_t note;
    logic           hit;
  } snap_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  sqs_pkg::note_t               note_number = '0;
  logic                         done;
  sqs_pkg::note_t               snapped_note;
  logic                         was_in_scale;
  logic                         cfg_write = 1'b0;
  sqs_pkg::cfg_idx_t            cfg_index = sqs_pkg::CFG_ROOT;
  logic [sqs_pkg::CfgWidth-1:0] cfg_data = '0;

  step_t           pending_items[$];
  snap_t           expected_snaps[$];
  sqs_pkg::pitch_t model_root = '0;
  sqs_pkg::kind_t  model_kind = '0;
  int unsigned     errors = 0;
  int unsigned     quiet_cycles = 0;

  scale_quantizer_snap_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .note_number  (note_number),
    .done         (done),
    .snapped_note (snapped_note),
    .was_in_scale (was_in_scale),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic sqs_pkg::mask_t scale_mask(input sqs_pkg::kind_t kind);
    sqs_pkg::mask_t m;
    case (sqs_pkg::scale_kind_t'(kind))
      sqs_pkg::KIND_MAJOR:       m = 12'b101010110101;
      sqs_pkg::KIND_NAT_MINOR:   m = 12'b010110101101;
      sqs_pkg::KIND_HARM_MINOR:  m = 12'b100110101101;
      sqs_pkg::KIND_MEL_MINOR:   m = 12'b101010101101;
      sqs_pkg::KIND_DORIAN:      m = 12'b011010101101;
      sqs_pkg::KIND_PHRYGIAN:    m = 12'b010110101011;
      sqs_pkg::KIND_LYDIAN:      m = 12'b101011010101;
      sqs_pkg::KIND_MIXOLYDIAN:  m = 12'b011010110101;
      sqs_pkg::KIND_LOCRIAN:     m = 12'b010101101011;
      sqs_pkg::KIND_PENTA_MAJOR: m = 12'b001010010101;
      sqs_pkg::KIND_PENTA_MINOR: m = 12'b010010101001;
      sqs_pkg::KIND_BLUES:       m = 12'b010011101001;
      sqs_pkg::KIND_WHOLE_TONE:  m = 12'b010101010101;
      default:                   m = 12'b111111111111;
    endcase
    return m;
  endfunction

  function automatic logic degree_in(input int n, input sqs_pkg::mask_t m);
    int deg;
    deg = (n + 24 - int'(model_root)) % 12;
    return m[deg];
  endfunction

  function automatic snap_t snap_note(input sqs_pkg::note_t n);
    snap_t          r;
    sqs_pkg::mask_t m;
    int             d;
    int             lo;
    int             hi;
    logic           found;
    m = scale_mask(model_kind);
    r.note = n;
    r.hit = degree_in(int'(n), m);
    found = r.hit;
    for (d = 1; d <= int'(sqs_pkg::SearchSpan); d++) begin
      lo = int'(n) - d;
      hi = int'(n) + d;
      if (!found && lo >= 0 && degree_in(lo, m)) begin
        r.note = sqs_pkg::note_t'(lo);
        found = 1'b1;
      end
      if (!found && hi <= int'(sqs_pkg::NoteMax) && degree_in(hi, m)) begin
        r.note = sqs_pkg::note_t'(hi);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic queue_note(input sqs_pkg::note_t n, input int unsigned idle);
    step_t s;
    s = '0;
    s.act = ACT_NOTE;
    s.note = n;
    s.idle_pct = idle[6:0];
    pending_items = {pending_items, s};
  endtask

  task automatic queue_cfg(input sqs_pkg::cfg_idx_t idx,
                           input logic [sqs_pkg::CfgWidth-1:0] data);
    step_t s;
    s = '0;
    s.act = ACT_CFG;
    s.idx = idx;
    s.data = data;
    pending_items = {pending_items, s};
  endtask

  always @(posedge clk) begin : drive_proc
    step_t                        head;
    logic                         take;
    logic                         nxt_start;
    logic                         nxt_wr;
    sqs_pkg::note_t               nxt_note;
    sqs_pkg::cfg_idx_t            nxt_idx;
    logic [sqs_pkg::CfgWidth-1:0] nxt_data;
    take = start && (busy === 1'b0);
    nxt_start = 1'b0;
    nxt_wr = 1'b0;
    nxt_note = note_number;
    nxt_idx = cfg_index;
    nxt_data = cfg_data;
    if (!rst) begin
      if (take) begin
        expected_snaps = {expected_snaps, snap_note(note_number)};
      end
      if (cfg_write) begin
        if (cfg_index == sqs_pkg::CFG_ROOT) begin
          model_root = cfg_data;
        end else begin
          model_kind = cfg_data;
        end
      end
      if (start && !take) begin
        nxt_start = 1'b1;
      end else if (pending_items.size() != 0) begin
        head = pending_items[0];
        if (head.act == ACT_CFG) begin
          if (expected_snaps.size() == 0) begin
            nxt_wr = 1'b1;
            nxt_idx = head.idx;
            nxt_data = head.data;
            void'(pending_items.pop_front());
          end
        end else if ($urandom_range(0, 99) >= head.idle_pct) begin
          nxt_start = 1'b1;
          nxt_note = head.note;
          void'(pending_items.pop_front());
        end
      end
    end
    start <= nxt_start;
    cfg_write <= nxt_wr;
    note_number <= nxt_note;
    cfg_index <= nxt_idx;
    cfg_data <= nxt_data;
  end

  always @(posedge clk) begin : check_proc
    snap_t want;
    if (!rst && done === 1'b1) begin
      if (expected_snaps.size() == 0) begin
        $display("%0t: unexpected result, expected none, got note %0d in_scale %0b",
                 $time, snapped_note, was_in_scale);
        errors++;
      end else begin
        want = expected_snaps.pop_front();
        if (snapped_note !== want.note) begin
          $display("%0t: snapped_note expected %0d, got %0d", $time, want.note, snapped_note);
          errors++;
        end
        if (was_in_scale !== want.hit) begin
          $display("%0t: was_in_scale expected %0b, got %0b", $time, want.hit, was_in_scale);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog_proc
    if (!rst) begin
      if ((start && busy === 1'b0) || done === 1'b1) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : stimulus_proc
    int unsigned     phase;
    int unsigned     i;
    int unsigned     phase_idle;
    int unsigned     burst_idle;
    sqs_pkg::pitch_t root;
    sqs_pkg::kind_t  kind;

    // Directed notes: range ends, ties, roots above eleven and undefined kinds.
    queue_note(7'd0, 0);
    queue_note(7'd127, 0);
    queue_cfg(sqs_pkg::CFG_ROOT, 4'd11);
    queue_cfg(sqs_pkg::CFG_KIND, sqs_pkg::KIND_WHOLE_TONE);
    queue_note(7'd0, 0);
    queue_note(7'd127, 0);
    queue_note(7'd64, 0);
    queue_cfg(sqs_pkg::CFG_ROOT, 4'd15);
    queue_cfg(sqs_pkg::CFG_KIND, sqs_pkg::KIND_UNDEF_B);
    queue_note(7'd0, 0);
    queue_note(7'd127, 0);
    queue_note(7'd5, 0);
    queue_cfg(sqs_pkg::CFG_ROOT, 4'd12);
    queue_cfg(sqs_pkg::CFG_KIND, sqs_pkg::KIND_PENTA_MINOR);
    queue_note(7'd0, 0);
    queue_note(7'd1, 0);
    queue_note(7'd2, 0);
    queue_note(7'd126, 0);
    queue_note(7'd127, 0);
    queue_cfg(sqs_pkg::CFG_ROOT, 4'd0);
    queue_cfg(sqs_pkg::CFG_KIND, sqs_pkg::KIND_MAJOR);
    queue_note(7'd61, 0);
    queue_note(7'd66, 0);
    queue_note(7'd0, 0);
    queue_note(7'd127, 0);

    for (phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: begin
          root = 4'd11;
          kind = sqs_pkg::KIND_WHOLE_TONE;
        end
        1: begin
          root = 4'd0;
          kind = sqs_pkg::KIND_CHROMATIC;
        end
        2: begin
          root = 4'd15;
          kind = sqs_pkg::KIND_UNDEF_A;
        end
        default: begin
          root = sqs_pkg::pitch_t'($urandom_range(0, 15));
          kind = sqs_pkg::kind_t'($urandom_range(0, 15));
        end
      endcase
      case (phase % 3)
        0:       phase_idle = 0;
        1:       phase_idle = 83;
        default: phase_idle = 24;
      endcase
      queue_cfg(sqs_pkg::CFG_ROOT, root);
      queue_cfg(sqs_pkg::CFG_KIND, kind);
      burst_idle = phase_idle;
      for (i = 0; i < NotesPerPhase; i++) begin
        if (i % 30 == 0) begin
          burst_idle = ($urandom_range(0, 3) == 0) ? 0 : phase_idle;
        end
        queue_note(sqs_pkg::note_t'($urandom_range(0, 127)), burst_idle);
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || start || cfg_write || expected_snaps.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    if (expected_snaps.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_snaps.size());
      errors++;
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
